### rtl/core/fp8cvt_pkg.sv
// Shared constants for the FP32 to FP8 E4M3 converter.
`timescale 1ns / 1ps
package fp8cvt_pkg;
	localparam logic [7:0] SAT_CODE = 8'h7E;
	localparam logic [7:0] NAN_CODE = 8'h7F;
	localparam logic [7:0] F32_BIAS = 8'd127;
	localparam logic [7:0] F8_BIAS  = 8'd7;
endpackage

### rtl/core/fp8cvt_core.sv
// Combinational FP32 to E4M3 conversion datapath.
`timescale 1ns / 1ps
module fp8cvt_core (
	input  logic [31:0] value_bits,
	output logic [7:0]  fp8_byte
);
	logic        sgn;
	logic [7:0]  e;
	logic [22:0] man;
	logic [9:0]  e8;
	logic [23:0] sig_sh;
	logic [2:0]  top3;
	logic [7:0]  res;
	logic [7:0]  rnd;
	logic        up;

	always_comb begin
		sgn    = value_bits[31];
		e      = value_bits[30:23];
		man    = value_bits[22:0];
		// e8 = E - 120, two's complement
		e8     = {2'b00, e} - {2'b00, fp8cvt_pkg::F32_BIAS} + {2'b00, fp8cvt_pkg::F8_BIAS};
		sig_sh = {1'b1, man} >> (3'd1 - e8[2:0]);
		top3   = man[22:20];
		res    = {sgn, e8[3:0], top3};
		up     = value_bits[19] && ((value_bits[18:0] != 19'd0) || top3[0]);
		rnd    = res + {7'd0, up};
		if (value_bits[30:0] == 31'd0) begin
			fp8_byte = {sgn, 7'd0};
		end else if (e == 8'hFF) begin
			fp8_byte = (man != 23'd0) ? fp8cvt_pkg::NAN_CODE
				: ({sgn, 7'd0} | fp8cvt_pkg::SAT_CODE);
		end else if (!e8[9] && e8 >= 10'd15) begin
			fp8_byte = {sgn, 7'd0} | fp8cvt_pkg::SAT_CODE;
		end else if (e8[9] || e8 == 10'd0) begin
			if (e8[9] && e8 < 10'h3FD)
				fp8_byte = {sgn, 7'd0};
			else
				fp8_byte = {sgn, 4'd0, sig_sh[22:20]};
		end else if (rnd[6:0] == 7'h7F) begin
			fp8_byte = {sgn, 7'd0} | fp8cvt_pkg::SAT_CODE;
		end else begin
			fp8_byte = rnd;
		end
	end
endmodule

### rtl/core/fp32_to_fp8_e4m3_convert_unit.sv
// Top level of the streaming FP32 to FP8 E4M3 converter.
`timescale 1ns / 1ps
// One FP32 pattern in, one E4M3 byte out per transaction, one per cycle
// sustained while m_tready stays high. The path is an input register, the
// conversion logic, then the output register. A transaction accepted into the
// input register is converted and captured in the output register before it
// is presented on the master side. The input side takes a transaction whenever
// the input register is empty or moves on this cycle. If a result waits on
// m_tready and the input register is also full, s_tready drops until the
// output drains. Normals round to nearest-even, subnormals truncate, overflow
// and infinity saturate to signed 0x7E, NaN gives 0x7F.
module fp32_to_fp8_e4m3_convert_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [7:0] fp8_byte
);
	logic        vld_s1;
	logic [31:0] data_s1;
	logic [7:0]  conv;
	logic        adv_s1;

	fp8cvt_core u_core (.value_bits(data_s1), .fp8_byte(conv));

	// output register free or draining this cycle
	assign adv_s1   = !m_tvalid || m_tready;
	assign s_tready = adv_s1 || !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv_s1) m_tvalid <= vld_s1;
			if (s_tready) vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) data_s1 <= s_tdata;
		if (adv_s1 && vld_s1) m_tdata <= conv;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s1 |=> m_tvalid) else $error("stage 1 item dropped");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && data_s1[30:23] == 8'hFF && data_s1[22:0] != 23'd0 |->
		conv == fp8cvt_pkg::NAN_CODE) else $error("bad NaN code");
endmodule

### verif/fp8cvt_checker.sv
// Checker for the FP32 to FP8 E4M3 converter: predicts and compares results.
`timescale 1ns / 1ps
module fp8cvt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	output int          fail_count,
	output int          pending
);
	logic [7:0] expected_bytes[$];

	function automatic logic [7:0] e4m3_of(input logic [31:0] v);
		logic       sgn;
		int         e8;
		logic [22:0] man;
		logic [23:0] full;
		logic [2:0] top3;
		logic [7:0] res;
		sgn = v[31];
		e8  = int'(v[30:23]) - int'(fp8cvt_pkg::F32_BIAS) + int'(fp8cvt_pkg::F8_BIAS);
		man = v[22:0];
		if (v[30:0] == 31'd0) return {sgn, 7'd0};
		if (v[30:23] == 8'hFF)
			return (man != 0) ? fp8cvt_pkg::NAN_CODE : {sgn, fp8cvt_pkg::SAT_CODE[6:0]};
		if (e8 >= 15) return {sgn, fp8cvt_pkg::SAT_CODE[6:0]};
		if (e8 <= 0) begin
			if (e8 < -3) return {sgn, 7'd0};
			full = {1'b1, man} >> (1 - e8);
			return {sgn, 4'd0, full[22:20]};
		end
		top3 = man[22:20];
		res = {sgn, e8[3:0], top3};
		if (v[19] && (v[18:0] != 0 || top3[0])) begin
			res = res + 8'd1;
			if (res[6:0] == 7'h7F) res = {sgn, fp8cvt_pkg::SAT_CODE[6:0]};
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready) expected_bytes = {expected_bytes, e4m3_of(s_tdata)};
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected result fp8_byte=%h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					if (m_tdata !== expected_bytes[0]) begin
						$error("fp8_byte: expected %h actual %h", expected_bytes[0], m_tdata);
						fail_count <= fail_count + 1;
					end
					void'(expected_bytes.pop_front());
				end
			end
		end
	end

	assign pending = expected_bytes.size();
endmodule

### verif/tb.sv
// Testbench top for the FP32 to FP8 E4M3 converter: stimulus and verdict.
`timescale 1ns / 1ps
module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	int          fail_count;
	int          pending;
	bit          stim_done = 1'b0;

	always #10 clk = ~clk;

	fp32_to_fp8_e4m3_convert_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	fp8cvt_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver stall pattern: long open stretches, a solid stall, then random backpressure
	always @(posedge clk) begin
		int phase;
		phase = int'(($time / 20) % 400);
		if (phase < 80) m_tready <= 1'b1;
		else if (phase < 120) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// hold one value on the bus until the transaction completes
	task automatic send_value(input logic [31:0] v);
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		logic [31:0] v;
		int pick;
		v = $urandom();
		pick = $urandom_range(0, 9);
		// bias exponents toward the E4M3 range and its edges
		if (pick < 6) v[30:23] = 8'($urandom_range(113, 136));
		else if (pick == 6) v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return v;
	endfunction

	initial begin
		logic [31:0] directed[$];
		int burst;
		directed = '{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
			32'h7F80_0000, 32'hFF80_0000, 32'h4400_0000, 32'h43E0_0000,
			32'h43EF_FFFF, 32'h43F0_0000, 32'h3C80_0000, 32'hBC00_0000,
			32'h3BFF_FFFF, 32'h3B00_0000, 32'h3AFF_FFFF, 32'h0000_0001,
			32'h3F88_0000, 32'h3F98_0000, 32'h3F88_0001, 32'h3F87_FFFF,
			32'h3FFF_FFFF, 32'h4000_0000, 32'hBF80_0000, 32'h5555_5555,
			32'hAAAA_AAAA};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_value(directed[i]);
		// drain fully once before the random part
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		for (int n = 0; n < 1150; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < 1150; k++, n++) send_value(random_value());
			if ($urandom_range(0, 2) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		// let the checker record the last input transaction first
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end
endmodule

### sim.f
rtl/core/fp8cvt_pkg.sv
rtl/core/fp8cvt_core.sv
rtl/core/fp32_to_fp8_e4m3_convert_unit.sv
verif/fp8cvt_checker.sv
verif/tb.sv
